@@ sv/window_filter_3x3_top_assert.svh @@
// Assertion macros for the checker of the 3x3 window filter.
// Each macro expects signals named clk and arst_n in the scope of its use.
`ifndef WINDOW_FILTER_3X3_TOP_ASSERT_SVH
`define WINDOW_FILTER_3X3_TOP_ASSERT_SVH

// Same-cycle implication.
`define WF3_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define WF3_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/wf3_pkg.sv @@
package wf3_pkg;

	localparam int PIX_W       = 8;
	localparam int ROW_W       = 12;
	localparam int COL_W       = 10;
	localparam int FWIDTH_W    = 11;
	localparam int FHEIGHT_W   = 13;
	localparam int MODE_W      = 3;
	localparam int CFG_ADDR_W  = 2;
	localparam int CFG_DATA_W  = 13;
	localparam int OUT_TDATA_W = 32;

	localparam logic [FWIDTH_W-1:0]  FWIDTH_RST  = 11'd256;
	localparam logic [FHEIGHT_W-1:0] FHEIGHT_RST = 13'd256;

	// floor(s / 9) == (s * 7282) >> 16 for every window sum up to 9 * 255.
	localparam int MEAN_RECIP = 7282;
	localparam int MEAN_SHIFT = 16;

	// Result queue depth; a power of two.
	localparam int FIFO_DEPTH = 8;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_FILTER_MODE  = 2'd2
	} cfg_reg_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_MEAN    = 3'd0,
		MODE_LAPLACE = 3'd1,
		MODE_MEDIAN  = 3'd2,
		MODE_MAX     = 3'd3,
		MODE_MIN     = 3'd4
	} mode_t;

	// Window bytes, index 4 is the center, 8 the newest pixel.
	typedef logic [8:0][PIX_W-1:0] win_t;

	// Result set of one input: bit 0 (r-1,c-1), bit 1 (r-1,c), bit 2 (r,c-1), bit 3 (r,c).
	typedef logic [3:0] res_mask_t;

	typedef struct packed {
		win_t             win;
		logic             border;
		res_mask_t        mask;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} item_t;

	typedef struct packed {
		logic [3:0][PIX_W-1:0] vals;
		res_mask_t             mask;
		logic [ROW_W-1:0]      row;
		logic [COL_W-1:0]      col;
	} entry_t;

endpackage

@@ sv/wf3_ram.sv @@
module wf3_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ sv/wf3_window.sv @@
module wf3_window import wf3_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [PIX_W-1:0]     pixel,
	input  logic [FWIDTH_W-1:0]  frame_width,
	input  logic [FHEIGHT_W-1:0] frame_height,
	output logic                 item_valid,
	output item_t                item
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;

	logic [31:0] w_in, h_in, wm1, hm1, c32, r32;
	logic        last_col, last_row, r_ge1, c_ge1;
	res_mask_t   mask_s0;
	logic        border_s0;

	// Stage 1 registers: line store read is in flight.
	logic             valid_s1;
	logic [PIX_W-1:0] pix_s1;
	logic [CW-1:0]    addr_s1;
	logic             border_s1;
	res_mask_t        mask_s1;
	logic [ROW_W-1:0] row_s1;
	logic [COL_W-1:0] col_s1;

	logic [2*PIX_W-1:0] rd_data;
	logic [PIX_W-1:0]   top, mid;
	win_t               win_q, win_next;

	always_comb begin
		w_in = 32'(frame_width);
		h_in = 32'(frame_height);
		if (w_in < 32'd3) begin
			w_in = 32'd3;
		end else if (w_in > 32'(MAX_WIDTH)) begin
			w_in = 32'(MAX_WIDTH);
		end
		if (h_in < 32'd3) begin
			h_in = 32'd3;
		end else if (h_in > 32'(MAX_HEIGHT)) begin
			h_in = 32'(MAX_HEIGHT);
		end
		wm1 = w_in - 32'd1;
		hm1 = h_in - 32'd1;
		c32 = 32'(col_q);
		r32 = 32'(row_q);
		last_col = (c32 >= wm1);
		last_row = (r32 >= hm1);
		r_ge1 = (r32 != 32'd0);
		c_ge1 = (c32 != 32'd0);
		mask_s0[0] = r_ge1 && c_ge1;
		mask_s0[1] = r_ge1 && last_col;
		mask_s0[2] = r_ge1 && last_row && c_ge1;
		mask_s0[3] = r_ge1 && last_row && last_col;
		// Border of the centered result at (r-1, c-1).
		border_s0 = (r32 == 32'd1) || (c32 == 32'd1) || (r32 >= h_in) || (c32 >= w_in);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : RW'(r32 + 32'd1);
			end else begin
				col_q <= CW'(c32 + 32'd1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1    <= pixel;
			addr_s1   <= col_q;
			border_s1 <= border_s0;
			mask_s1   <= mask_s0;
			row_s1    <= r32[ROW_W-1:0];
			col_s1    <= c32[COL_W-1:0];
		end
	end

	// Each entry holds {row two above, row above} for its column. Two items in
	// a row never share a column, so the write of one never meets the read of
	// the next at the same address.
	wf3_ram #(
		.WIDTH(2 * PIX_W),
		.DEPTH(MAX_WIDTH)
	) u_lines (
		.clk  (clk),
		.we   (valid_s1),
		.waddr(addr_s1),
		.wdata({mid, pix_s1}),
		.re   (accept),
		.raddr(col_q),
		.rdata(rd_data)
	);

	assign top = rd_data[2*PIX_W-1:PIX_W];
	assign mid = rd_data[PIX_W-1:0];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			win_next[3*k]     = win_q[3*k+1];
			win_next[3*k + 1] = win_q[3*k+2];
		end
		win_next[2] = top;
		win_next[5] = mid;
		win_next[8] = pix_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q      <= '0;
			item_valid <= 1'b0;
		end else begin
			item_valid <= valid_s1;
			if (valid_s1) begin
				win_q <= win_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			item.win    <= win_next;
			item.border <= border_s1;
			item.mask   <= mask_s1;
			item.row    <= row_s1;
			item.col    <= col_s1;
		end
	end

endmodule

@@ sv/wf3_filter.sv @@
module wf3_filter import wf3_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  item_t             item,
	input  logic [MODE_W-1:0] filter_mode,
	output logic              entry_valid,
	output entry_t            entry
);

	// Sorted triple: [2] largest, [1] middle, [0] smallest.
	function automatic logic [2:0][PIX_W-1:0] sort3(
		input logic [PIX_W-1:0] a,
		input logic [PIX_W-1:0] b,
		input logic [PIX_W-1:0] c
	);
		logic [PIX_W-1:0] l1, h1, l2, h2, l3, h3;
		l1 = (a < b) ? a : b;
		h1 = (a < b) ? b : a;
		l2 = (h1 < c) ? h1 : c;
		h2 = (h1 < c) ? c : h1;
		l3 = (l1 < l2) ? l1 : l2;
		h3 = (l1 < l2) ? l2 : l1;
		return {h2, h3, l3};
	endfunction

	logic [2:0][PIX_W-1:0] col_a, col_b, col_c;
	logic [11:0]           sum_s2;

	logic                  valid_s3;
	logic [2:0][PIX_W-1:0] lo_s3, md_s3, hi_s3;
	logic [11:0]           sum_s3;
	logic [PIX_W-1:0]      ctr_s3, w5_s3, w7_s3, w8_s3;
	logic                  border_s3;
	res_mask_t             mask_s3;
	logic [ROW_W-1:0]      row_s3;
	logic [COL_W-1:0]      col_s3;

	// Stage 2: sort each window column, add the nine pixels.
	always_comb begin
		col_a  = sort3(item.win[0], item.win[3], item.win[6]);
		col_b  = sort3(item.win[1], item.win[4], item.win[7]);
		col_c  = sort3(item.win[2], item.win[5], item.win[8]);
		sum_s2 = (12'(item.win[0]) + 12'(item.win[1]) + 12'(item.win[2]))
			+ (12'(item.win[3]) + 12'(item.win[4]) + 12'(item.win[5]))
			+ (12'(item.win[6]) + 12'(item.win[7]) + 12'(item.win[8]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid) begin
			lo_s3     <= {col_c[0], col_b[0], col_a[0]};
			md_s3     <= {col_c[1], col_b[1], col_a[1]};
			hi_s3     <= {col_c[2], col_b[2], col_a[2]};
			sum_s3    <= sum_s2;
			ctr_s3    <= item.win[4];
			w5_s3     <= item.win[5];
			w7_s3     <= item.win[7];
			w8_s3     <= item.win[8];
			border_s3 <= item.border;
			mask_s3   <= item.mask;
			row_s3    <= item.row;
			col_s3    <= item.col;
		end
	end

	// Stage 3: the median is the middle of (largest low, middle mid, smallest high).
	logic [2:0][PIX_W-1:0] lo_sort, md_sort, hi_sort, fin_sort;
	logic [24:0]           mean_prod;
	logic [PIX_W-1:0]      mean_v, lap_v, res0;
	logic [11:0]           ctr9, lap_abs;
	logic signed [12:0]    lap_d;

	always_comb begin
		lo_sort   = sort3(lo_s3[0], lo_s3[1], lo_s3[2]);
		md_sort   = sort3(md_s3[0], md_s3[1], md_s3[2]);
		hi_sort   = sort3(hi_s3[0], hi_s3[1], hi_s3[2]);
		fin_sort  = sort3(lo_sort[2], md_sort[1], hi_sort[0]);
		mean_prod = 25'(sum_s3) * 25'(MEAN_RECIP);
		mean_v    = PIX_W'(mean_prod >> MEAN_SHIFT);
		ctr9      = 12'({ctr_s3, 3'b000}) + 12'(ctr_s3);
		lap_d     = $signed({1'b0, ctr9}) - $signed({1'b0, sum_s3});
		lap_abs   = lap_d[12] ? 12'(-lap_d) : lap_d[11:0];
		lap_v     = (lap_abs > 12'd255) ? 8'd255 : lap_abs[PIX_W-1:0];
		case (filter_mode)
			MODE_MEAN:    res0 = mean_v;
			MODE_LAPLACE: res0 = lap_v;
			MODE_MEDIAN:  res0 = fin_sort[1];
			MODE_MAX:     res0 = hi_sort[2];
			MODE_MIN:     res0 = lo_sort[0];
			default:      res0 = ctr_s3;
		endcase
		if (border_s3) begin
			res0 = ctr_s3;
		end
	end

	assign entry_valid = valid_s3;
	assign entry.vals  = {w8_s3, w7_s3, w5_s3, res0};
	assign entry.mask  = mask_s3;
	assign entry.row   = row_s3;
	assign entry.col   = col_s3;

endmodule

@@ sv/wf3_outq.sv @@
module wf3_outq import wf3_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic             push,
	input  entry_t           entry,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [PIX_W-1:0] pixel_out,
	output logic [ROW_W-1:0] out_row,
	output logic [COL_W-1:0] out_col,
	output logic             run_last,
	output logic             frame_done
);

	localparam int PW   = $clog2(FIFO_DEPTH);
	localparam int CNTW = $clog2(FIFO_DEPTH + 1);

	entry_t           fifo_q [FIFO_DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CNTW-1:0]  count_q, inflight_q;
	res_mask_t        sent_q;

	entry_t           head;
	res_mask_t        pend, sel, rest;
	logic             nonempty, fire, pop;
	logic [ROW_W-1:0] row_m1;
	logic [COL_W-1:0] col_m1;

	always_comb begin
		head      = fifo_q[rd_ptr_q];
		nonempty  = (count_q != '0);
		pend      = head.mask & ~sent_q;
		sel       = pend & (~pend + 4'd1);
		rest      = pend & ~sel;
		out_valid = nonempty && (pend != '0);
		fire      = out_valid && out_ready;
		run_last  = (rest == '0);
		// An item with no results leaves the queue without a word.
		pop       = nonempty && ((pend == '0) || (fire && run_last));
		row_m1    = head.row - 12'd1;
		col_m1    = head.col - 10'd1;
		frame_done = sel[3];
		if (sel[0]) begin
			pixel_out = head.vals[0];
			out_row   = row_m1;
			out_col   = col_m1;
		end else if (sel[1]) begin
			pixel_out = head.vals[1];
			out_row   = row_m1;
			out_col   = head.col;
		end else if (sel[2]) begin
			pixel_out = head.vals[2];
			out_row   = head.row;
			out_col   = col_m1;
		end else begin
			pixel_out = head.vals[3];
			out_row   = head.row;
			out_col   = head.col;
		end
	end

	// Every accepted item holds a queue slot from acceptance until it leaves.
	assign in_ready = (inflight_q < CNTW'(FIFO_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			count_q    <= '0;
			inflight_q <= '0;
			sent_q     <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
				sent_q   <= '0;
			end else if (fire) begin
				sent_q <= sent_q | sel;
			end
			count_q    <= count_q + CNTW'(push) - CNTW'(pop);
			inflight_q <= inflight_q + CNTW'(accept) - CNTW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= entry;
		end
	end

endmodule

@@ sv/window_filter_3x3_top.sv @@
// 3x3 window filter for 8-bit grayscale frames.
// Pixels enter on the s_ channel in raster order, one word per pixel. Results leave on
// the m_ channel, each tagged with its row and column. The previous two rows are kept
// in one line store RAM; a 3x3 register window slides over them.
// A pixel at (r, c) gives the result centered on (r-1, c-1), so output trails input by
// one row and one column. Last-column and last-row pixels also flush the edge pixels,
// up to four words per input; m_tlast marks the last word of each input, m_tuser the
// frame's final pixel. Border pixels pass through unfiltered.
// An accepted pixel passes the stage 1 registers, the window item register, the stage 3
// registers and the result queue before its first word is presented. Throughput: one
// pixel per clock; the output emits one word per clock while m_tready is high, so inputs
// that cause two or more words slow intake once the eight-entry result queue fills.
// The line store takes one read and one write each cycle.
// Stalling m_tready holds the current word and fills the queue; s_tready drops when
// eight inputs are accepted but not yet fully delivered.
// Reset clears the row and column counters, the window and the queue, and sets
// width and height to 256 and mode to mean. Write configuration only while idle.
module window_filter_3x3_top import wf3_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [PIX_W-1:0]       s_tdata,   // [7:0] pixel_in
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // [7:0] pixel_out, [19:8] out_row, [29:20] out_col
	output logic                   m_tlast,
	output logic                   m_tuser,   // [0] frame_done
	input  logic                   cfg_we,
	input  logic [CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

	logic [FWIDTH_W-1:0]  frame_width_q;
	logic [FHEIGHT_W-1:0] frame_height_q;
	logic [MODE_W-1:0]    filter_mode_q;

	logic             accept;
	logic             item_valid, entry_valid;
	item_t            item;
	entry_t           entry;
	logic [PIX_W-1:0] pixel_out;
	logic [ROW_W-1:0] out_row;
	logic [COL_W-1:0] out_col;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FWIDTH_RST;
			frame_height_q <= FHEIGHT_RST;
			filter_mode_q  <= MODE_MEAN;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata[FWIDTH_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_wdata[FHEIGHT_W-1:0];
				REG_FILTER_MODE:  filter_mode_q  <= cfg_wdata[MODE_W-1:0];
				default: ;
			endcase
		end
	end

	assign accept = s_tvalid && s_tready;

	wf3_window #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_window (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.pixel       (s_tdata),
		.frame_width (frame_width_q),
		.frame_height(frame_height_q),
		.item_valid  (item_valid),
		.item        (item)
	);

	wf3_filter u_filter (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.filter_mode(filter_mode_q),
		.entry_valid(entry_valid),
		.entry      (entry)
	);

	wf3_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.push      (entry_valid),
		.entry     (entry),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.pixel_out (pixel_out),
		.out_row   (out_row),
		.out_col   (out_col),
		.run_last  (m_tlast),
		.frame_done(m_tuser)
	);

	assign m_tdata = {2'b00, out_col, out_row, pixel_out};

endmodule

@@ sv/wf3_checker.sv @@
`include "window_filter_3x3_top_assert.svh"

module wf3_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tlast,
	input logic        m_tuser
);

	// The frame's final pixel is always the last word of its input.
	`WF3_ASSERT_IMP(a_done_is_last, m_tvalid && m_tuser, m_tlast, "frame end word not last")

	// The words caused by one input follow each other without a gap.
	`WF3_ASSERT_NXT(a_run_no_gap, m_tvalid && m_tready && !m_tlast, m_tvalid, "gap inside run")

	`WF3_ASSERT_NXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "stalled word changed")

endmodule

bind window_filter_3x3_top wf3_checker u_checker (.*);

@@ dv/window_filter_3x3_top_tb.sv @@
`timescale 1ns / 1ps

module window_filter_3x3_top_tb import wf3_pkg::*; ();

	localparam int          MAX_W        = 1024;
	localparam int          MAX_H        = 4096;
	localparam int          RANDOM_ITEMS = 110;
	localparam int          WIDE_ITEMS   = 24;
	localparam int          DRAIN_CYCLES = 8;
	localparam int          CYCLE_LIMIT  = 1_500_000;
	localparam logic [2:0]  MODE_PASS_CENTRE = 3'd7;

	// Register select bits for program_regs.
	localparam logic [2:0]  SEL_WIDTH  = 3'b001;
	localparam logic [2:0]  SEL_HEIGHT = 3'b010;
	localparam logic [2:0]  SEL_MODE   = 3'b100;
	localparam logic [2:0]  SEL_ALL    = 3'b111;

	typedef enum int {PIX_RANDOM, PIX_CHECKER} pix_style_t;

	typedef struct packed {
		logic [PIX_W-1:0] pix;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             last;
		logic             done;
	} filtered_word_t;

	class pixel_scoreboard;
		logic [PIX_W-1:0]     line_one_up[MAX_W];
		logic [PIX_W-1:0]     line_two_up[MAX_W];
		logic [PIX_W-1:0]     win[9];
		int                   cur_row;
		int                   cur_col;
		logic [FWIDTH_W-1:0]  width_reg;
		logic [FHEIGHT_W-1:0] height_reg;
		logic [MODE_W-1:0]    mode_reg;
		filtered_word_t       expected_words[$];
		int                   errors;
		int                   pixels_in;
		int                   words_out;
		int                   frames_done;
		logic [7:0]           modes_hit;

		function new();
			foreach (line_one_up[i]) begin
				line_one_up[i] = '0;
				line_two_up[i] = '0;
			end
			foreach (win[i]) win[i] = '0;
			cur_row     = 0;
			cur_col     = 0;
			width_reg   = FWIDTH_RST;
			height_reg  = FHEIGHT_RST;
			mode_reg    = MODE_MEAN;
			errors      = 0;
			pixels_in   = 0;
			words_out   = 0;
			frames_done = 0;
			modes_hit   = '0;
		endfunction

		function int clamp_dim(int v, int hi);
			if (v < 3) return 3;
			if (v > hi) return hi;
			return v;
		endfunction

		function int width_in_use();
			return clamp_dim(int'(width_reg), MAX_W);
		endfunction

		function int height_in_use();
			return clamp_dim(int'(height_reg), MAX_H);
		endfunction

		function int pending();
			return expected_words.size();
		endfunction

		function bit at_frame_start();
			return cur_row == 0 && cur_col == 0;
		endfunction

		// Pixels still to come before the counters wrap to the next frame.
		function int frame_remaining();
			int w;
			int h;
			int in_row;
			int rows_after;
			w = width_in_use();
			h = height_in_use();
			in_row = (cur_col >= w - 1) ? 1 : w - cur_col;
			rows_after = (cur_row >= h - 1) ? 0 : h - 1 - cur_row;
			return in_row + rows_after * w;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_FRAME_WIDTH:  width_reg  = val[FWIDTH_W-1:0];
				REG_FRAME_HEIGHT: height_reg = val[FHEIGHT_W-1:0];
				REG_FILTER_MODE:  mode_reg   = val[MODE_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [PIX_W-1:0] filter_window();
			int               sum;
			int               diff;
			logic [PIX_W-1:0] s[9];
			logic [PIX_W-1:0] t;
			sum = 0;
			for (int i = 0; i < 9; i++) begin
				sum += int'(win[i]);
				s[i] = win[i];
			end
			case (mode_reg)
				MODE_MEAN: return PIX_W'(sum / 9);
				MODE_LAPLACE: begin
					diff = 9 * int'(win[4]) - sum;
					if (diff < 0) diff = -diff;
					if (diff > 255) diff = 255;
					return PIX_W'(diff);
				end
				MODE_MEDIAN, MODE_MAX, MODE_MIN: begin
					for (int i = 0; i < 8; i++)
						for (int j = 0; j < 8 - i; j++)
							if (s[j] > s[j+1]) begin
								t = s[j];
								s[j] = s[j+1];
								s[j+1] = t;
							end
					if (mode_reg == MODE_MEDIAN) return s[4];
					if (mode_reg == MODE_MAX) return s[8];
					return s[0];
				end
				default: return win[4];
			endcase
		endfunction

		function void push_word(logic [PIX_W-1:0] pix, int row, int col, bit done);
			filtered_word_t wd;
			wd.pix  = pix;
			wd.row  = ROW_W'(row);
			wd.col  = COL_W'(col);
			wd.last = 1'b0;
			wd.done = done;
			expected_words.push_back(wd);
		endfunction

		// Advance the window by one accepted pixel and queue the words it releases.
		function void note_pixel(logic [PIX_W-1:0] pix);
			int               w;
			int               h;
			int               r;
			int               c;
			int               first;
			bit               last_col;
			bit               last_row;
			bit               border;
			logic [PIX_W-1:0] top;
			logic [PIX_W-1:0] mid;
			w = width_in_use();
			h = height_in_use();
			r = cur_row;
			c = cur_col;
			last_col = c >= w - 1;
			last_row = r >= h - 1;
			top = line_two_up[c];
			mid = line_one_up[c];
			line_two_up[c] = mid;
			line_one_up[c] = pix;
			for (int k = 0; k < 3; k++) begin
				win[k*3]   = win[k*3+1];
				win[k*3+1] = win[k*3+2];
			end
			win[2] = top;
			win[5] = mid;
			win[8] = pix;
			first = expected_words.size();
			if (r >= 1) begin
				if (c >= 1) begin
					border = (r - 1 == 0) || (c - 1 == 0) || (r - 1 >= h - 1) || (c - 1 >= w - 1);
					if (!border) modes_hit[mode_reg] = 1'b1;
					push_word(border ? win[4] : filter_window(), r - 1, c - 1, 1'b0);
				end
				if (last_col) push_word(win[5], r - 1, c, 1'b0);
				if (last_row) begin
					if (c >= 1) push_word(win[7], r, c - 1, 1'b0);
					if (last_col) push_word(win[8], r, c, 1'b1);
				end
			end
			if (expected_words.size() > first) expected_words[$].last = 1'b1;
			if (last_col) begin
				cur_col = 0;
				cur_row = last_row ? 0 : r + 1;
			end else begin
				cur_col = c + 1;
			end
			pixels_in++;
		endfunction

		function void compare_field(string name, int unsigned e, int unsigned a);
			if (e !== a) begin
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, e, a);
				errors++;
			end
		endfunction

		function void check_word(filtered_word_t got);
			filtered_word_t exp;
			words_out++;
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected word, expected none, got pix %0d row %0d col %0d",
					$time, got.pix, got.row, got.col);
				errors++;
				return;
			end
			exp = expected_words.pop_front();
			compare_field("pixel_out", 32'(exp.pix), 32'(got.pix));
			compare_field("out_row", 32'(exp.row), 32'(got.row));
			compare_field("out_col", 32'(exp.col), 32'(got.col));
			compare_field("run_last", 32'(exp.last), 32'(got.last));
			compare_field("frame_done", 32'(exp.done), 32'(got.done));
			if (exp.done) frames_done++;
		endfunction
	endclass

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [PIX_W-1:0]       s_tdata   = '0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tlast;
	logic                   m_tuser;
	logic                   cfg_we    = 1'b0;
	logic [CFG_ADDR_W-1:0]  cfg_addr  = REG_FRAME_WIDTH;
	logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

	pixel_scoreboard sb = new();
	bit              src_free = 1'b0;
	bit              snk_free = 1'b0;
	int unsigned     hold_req = 0;
	int              cycle_count = 0;
	filtered_word_t  seen_word;

	window_filter_3x3_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d words outstanding", $time, sb.pending());
			$display("Simulation FAILED");
			$finish;
		end
		if (arst_n && m_tvalid && m_tready) begin
			seen_word.pix  = m_tdata[PIX_W-1:0];
			seen_word.row  = m_tdata[PIX_W+ROW_W-1:PIX_W];
			seen_word.col  = m_tdata[PIX_W+ROW_W+COL_W-1:PIX_W+ROW_W];
			seen_word.last = m_tlast;
			seen_word.done = m_tuser;
			sb.check_word(seen_word);
		end
	end

	// Output side: random stalls, plus long hold-offs on request.
	initial begin : sink_side
		int unsigned gap;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			gap = snk_free ? 0 : $urandom_range(0, 16);
			if (hold_req != 0) begin
				gap = hold_req;
				hold_req = 0;
			end
			if (gap != 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	task automatic send_pixel(input logic [PIX_W-1:0] pix);
		int unsigned gap;
		gap = src_free ? 0 : $urandom_range(0, 16);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= pix;
		do @(posedge clk); while (!s_tready);
		sb.note_pixel(pix);
		@(negedge clk);
	endtask

	task automatic send_run(input int count, input pix_style_t style);
		logic [PIX_W-1:0] pix;
		for (int i = 0; i < count; i++) begin
			if (style == PIX_CHECKER)
				pix = ((sb.cur_row + sb.cur_col) % 2 != 0) ? 8'hFF : 8'h00;
			else if ($urandom_range(0, 7) == 0)
				pix = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			else
				pix = PIX_W'($urandom_range(0, 255));
			send_pixel(pix);
		end
	endtask

	// Idle the input, wait for every expected word, then for the pipeline to
	// empty behind inputs that released nothing.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic program_regs(input logic [2:0] sel, input logic [CFG_DATA_W-1:0] w,
		input logic [CFG_DATA_W-1:0] h, input logic [CFG_DATA_W-1:0] m);
		cfg_reg_t              idx;
		logic [CFG_DATA_W-1:0] val;
		for (int i = 0; i < 3; i++) begin
			idx = cfg_reg_t'(i);
			val = (idx == REG_FRAME_WIDTH) ? w : (idx == REG_FRAME_HEIGHT) ? h : m;
			if (sel[i]) begin
				cfg_we    <= 1'b1;
				cfg_addr  <= idx;
				cfg_wdata <= val;
				@(posedge clk);
				sb.write_reg(idx, val);
				@(negedge clk);
			end
		end
		cfg_we <= 1'b0;
	endtask

	initial begin : stimulus
		logic [2:0]            dir_modes[5];
		logic [2:0]            sel;
		logic [CFG_DATA_W-1:0] w;
		logic [CFG_DATA_W-1:0] h;
		logic [CFG_DATA_W-1:0] m;
		int                    random_items;
		int                    phase;
		int                    remain;
		int                    count;
		int                    pick;
		dir_modes = '{MODE_LAPLACE, MODE_MEDIAN, MODE_MAX, MODE_MIN, MODE_PASS_CENTRE};
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Three-wide strip with a checkerboard of 0 and 255; each row from the
		// third to the eighth yields one interior pixel, filtered with a different mode.
		// The height is then cut below the current row, which ends the frame.
		program_regs(SEL_ALL, 13'd3, 13'd8191, CFG_DATA_W'(MODE_MEAN));
		for (int r = 0; r < 9; r++) begin
			if (r >= 3) begin
				drain_results();
				if (r < 8)
					program_regs(SEL_MODE, '0, '0, CFG_DATA_W'(dir_modes[r-3]));
				else
					program_regs(SEL_WIDTH | SEL_HEIGHT, 13'd0, 13'd2, '0);
			end
			send_run(3, PIX_CHECKER);
		end

		// Part of a first line at the widest line length, with the height
		// clamped up; the next phase narrows the line in the middle of the frame.
		drain_results();
		program_regs(SEL_ALL, 13'd2047, 13'd0, CFG_DATA_W'(MODE_LAPLACE));
		send_run(WIDE_ITEMS, PIX_RANDOM);

		random_items = 0;
		phase = 0;
		while (random_items < RANDOM_ITEMS) begin
			drain_results();
			src_free = ($urandom_range(0, 3) == 0);
			snk_free = ($urandom_range(0, 3) == 0);
			if (phase == 0) begin
				// Sink stalls while the source streams, so the result queue fills.
				sel = SEL_ALL;
				w = 5;
				h = 6;
				m = CFG_DATA_W'($urandom_range(0, 4));
				src_free = 1'b1;
				snk_free = 1'b0;
				hold_req = 300;
			end else begin
				sel = ($urandom_range(0, 3) != 0) ? 3'($urandom_range(1, 7)) : 3'b000;
				m = ($urandom_range(0, 9) < 8) ? CFG_DATA_W'($urandom_range(0, 4)) :
					CFG_DATA_W'($urandom_range(5, 7));
				pick = $urandom_range(0, 19);
				h = (pick == 0) ? CFG_DATA_W'($urandom_range(0, 2)) :
					(pick == 1) ? CFG_DATA_W'($urandom_range(4096, 8191)) :
					CFG_DATA_W'($urandom_range(3, 8));
				// Mid-frame the line length may only shrink, so that no window
				// ever reaches a line store column that was never filled.
				pick = $urandom_range(0, 19);
				if (!sb.at_frame_start())
					w = CFG_DATA_W'($urandom_range(0,
						(sb.width_in_use() < 12) ? sb.width_in_use() : 12));
				else if (pick == 0)
					w = CFG_DATA_W'($urandom_range(0, 2));
				else if (pick == 1)
					w = CFG_DATA_W'($urandom_range(1024, 2047));
				else
					w = CFG_DATA_W'($urandom_range(3, 12));
				if ($urandom_range(0, 9) == 0) hold_req = $urandom_range(40, 200);
			end
			program_regs(sel, w, h, m);
			remain = sb.frame_remaining();
			if (phase == 0)
				count = remain;
			else if (remain > 150 || $urandom_range(0, 4) == 0)
				count = $urandom_range(1, 40);
			else
				count = remain;
			if (phase != 0 && count > RANDOM_ITEMS - random_items)
				count = RANDOM_ITEMS - random_items;
			send_run(count, PIX_RANDOM);
			random_items += count;
			phase++;
		end

		drain_results();
		$display("Run covered %0d pixels and %0d result words over %0d completed frames.",
			sb.pixels_in, sb.words_out, sb.frames_done);
		$display("Interior pixels were filtered in modes %b (one bit per mode code).",
			sb.modes_hit);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

@@ window_filter_3x3_top.f @@
+incdir+sv
sv/wf3_pkg.sv
sv/wf3_ram.sv
sv/wf3_window.sv
sv/wf3_filter.sv
sv/wf3_outq.sv
sv/window_filter_3x3_top.sv
sv/wf3_checker.sv
dv/window_filter_3x3_top_tb.sv
